### rtl/core/ssc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the statement splitter.
// No dependencies; imported by every module of the block.
package ssc_pkg;

    localparam int unsigned AHEAD  = 5;
    localparam int unsigned WINDOW = 6;

    localparam logic [7:0] TERM_RESET = 8'd59;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_H       = 8'h68;
    localparam logic [7:0] CH_T       = 8'h74;
    localparam logic [7:0] CH_M       = 8'h6D;
    localparam logic [7:0] CH_L       = 8'h6C;

    localparam logic [2:0] TAIL_SKIP = 3'd6;
    localparam logic [2:0] LAST_F    = 3'd5;
    localparam logic [2:0] HTML_F    = 3'd4;

    typedef logic [WINDOW-1:0][7:0] win_t;

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_LINE,
        MODE_BLOCK,
        MODE_HTML
    } scan_mode_t;

    typedef enum logic {
        SEQ_STREAM,
        SEQ_FLUSH
    } seq_t;

    typedef struct packed {
        scan_mode_t  mode;
        logic [15:0] paren;
        logic [15:0] bracket;
        logic        quote;
        logic [7:0]  hist0;
        logic [7:0]  hist1;
        logic [2:0]  skip;
    } scan_state_t;

    localparam scan_state_t SCAN_CLEAR = '{
        mode:    MODE_NORMAL,
        paren:   16'd0,
        bracket: 16'd0,
        quote:   1'b0,
        hist0:   CH_LF,
        hist1:   CH_LF,
        skip:    3'd0
    };

    typedef struct packed {
        logic [7:0] in_byte;
        logic       text_start;
        logic       text_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       statement_end;
        logic       text_done;
    } out_item_t;

    typedef struct packed {
        logic       emit;
        logic [7:0] ob;
        logic       se;
    } judge_res_t;

    typedef struct packed {
        logic      valid;
        out_item_t item;
    } out_push_t;

    function automatic logic either_case(input logic [7:0] b, input logic [7:0] lower);
        return (b == lower) || (b == (lower - 8'd32));
    endfunction

    function automatic logic html_word(input logic [7:0] b0, input logic [7:0] b1,
                                       input logic [7:0] b2, input logic [7:0] b3);
        return either_case(b0, CH_H) && either_case(b1, CH_T) &&
               either_case(b2, CH_M) && either_case(b3, CH_L);
    endfunction

endpackage

### rtl/core/ssc_judge.sv
`timescale 1ns / 1ps
// Judges the head byte of the window: keep or drop, statement end, next scan state.
// Depends on ssc_pkg.
module ssc_judge (
    input  ssc_pkg::win_t        win,
    input  logic [2:0]           follow,
    input  ssc_pkg::scan_state_t st,
    input  logic [7:0]           terminator,
    output ssc_pkg::judge_res_t  res,
    output ssc_pkg::scan_state_t st_out
);
    import ssc_pkg::*;

    logic [7:0] c;

    assign c = win[0];

    always_comb begin
        res.emit = 1'b0;
        res.ob   = c;
        res.se   = 1'b0;
        st_out   = st;
        if (st.skip != 3'd0) begin
            st_out.skip = st.skip - 3'd1;
        end else begin
            unique case (st.mode)
                MODE_LINE: begin
                    if (c == CH_CR || c == CH_LF) begin
                        res.emit    = 1'b1;
                        st_out.mode = MODE_NORMAL;
                    end else if (follow == 3'd0) begin
                        res.emit = 1'b1;
                    end
                end
                MODE_BLOCK: begin
                    if (st.hist0 == CH_STAR && c == CH_SLASH) begin
                        res.emit    = 1'b1;
                        st_out.mode = MODE_NORMAL;
                    end else if (follow == 3'd0) begin
                        res.emit = 1'b1;
                    end
                end
                MODE_HTML: begin
                    if (follow == LAST_F) begin
                        if (c == CH_LT && win[1] == CH_SLASH &&
                            html_word(win[2], win[3], win[4], win[5])) begin
                            res.ob      = CH_SPACE;
                            res.emit    = 1'b1;
                            st_out.skip = TAIL_SKIP;
                            st_out.mode = MODE_NORMAL;
                        end
                    end else begin
                        // unclosed run near text end: fall back to plain text
                        res.emit    = 1'b1;
                        st_out.mode = MODE_NORMAL;
                    end
                end
                MODE_NORMAL: begin
                    if (c == terminator && st.paren == 16'd0 && st.bracket == 16'd0 &&
                        !st.quote) begin
                        res.emit       = 1'b1;
                        res.se         = 1'b1;
                        st_out.paren   = 16'd0;
                        st_out.bracket = 16'd0;
                        st_out.quote   = 1'b0;
                    end else begin
                        if (!st.quote) begin
                            if (c == CH_LPAREN) st_out.paren = st.paren + 16'd1;
                            if (c == CH_RPAREN) st_out.paren = st.paren - 16'd1;
                            if (c == CH_LBRACK) st_out.bracket = st.bracket + 16'd1;
                            if (c == CH_RBRACK) st_out.bracket = st.bracket - 16'd1;
                        end
                        if (c == CH_QUOTE) st_out.quote = ~st.quote;
                        if (c == CH_SLASH && st.hist0 == CH_SLASH && st.hist1 == CH_LF) begin
                            st_out.mode = MODE_LINE;
                            if (follow == 3'd0) res.emit = 1'b1;
                        end else if (c == CH_STAR && st.hist0 == CH_SLASH) begin
                            st_out.mode = MODE_BLOCK;
                            if (follow == 3'd0) res.emit = 1'b1;
                        end else if (c == CH_LT && follow >= HTML_F &&
                                     html_word(win[1], win[2], win[3], win[4])) begin
                            if (follow == LAST_F) st_out.mode = MODE_HTML;
                            else res.emit = 1'b1;
                        end else begin
                            res.emit = 1'b1;
                        end
                    end
                end
                default: begin
                    st_out.mode = MODE_NORMAL;
                end
            endcase
        end
        st_out.hist1 = st.hist0;
        st_out.hist0 = c;
    end

endmodule

### rtl/core/ssc_core.sv
`timescale 1ns / 1ps
// Scan state, lookahead window and end-of-text flush sequencer.
// Depends on ssc_pkg and ssc_judge.
module ssc_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  ssc_pkg::in_item_t   s_item,
    input  logic                s_fire,
    input  logic [7:0]          terminator,
    input  logic                out_free,
    output logic                take_ok,
    output ssc_pkg::out_push_t  push
);
    import ssc_pkg::*;

    seq_t        seq_reg, seq_next;
    scan_state_t st_reg, st_next, st_eff, st_judged;
    win_t        la_reg, la_next, win;
    logic [2:0]  cnt_reg, cnt_next, cnt_eff, follow;
    logic        pend_valid_reg, pend_valid_next;
    logic [7:0]  pend_byte_reg, pend_byte_next;
    logic        pend_se_reg, pend_se_next;
    judge_res_t  jres;

    // a text start clears the scan before its own byte is queued
    assign st_eff  = (s_fire && s_item.text_start) ? SCAN_CLEAR : st_reg;
    assign cnt_eff = (s_fire && s_item.text_start) ? 3'd0 : cnt_reg;

    always_comb begin
        if (seq_reg == SEQ_FLUSH) begin
            win    = la_reg;
            follow = cnt_reg - 3'd1;
        end else begin
            win    = {s_item.in_byte, la_reg[AHEAD-1:0]};
            follow = LAST_F;
        end
    end

    ssc_judge u_judge (
        .win        (win),
        .follow     (follow),
        .st         (st_eff),
        .terminator (terminator),
        .res        (jres),
        .st_out     (st_judged)
    );

    // sequencer next state
    always_comb begin
        seq_next = seq_reg;
        unique case (seq_reg)
            SEQ_STREAM: if (s_fire && s_item.text_end) seq_next = SEQ_FLUSH;
            SEQ_FLUSH:  if (out_free && cnt_reg == 3'd0) seq_next = SEQ_STREAM;
            default:    seq_next = SEQ_STREAM;
        endcase
    end

    // sequencer outputs and datapath updates
    always_comb begin
        take_ok         = (seq_reg == SEQ_STREAM) && out_free;
        st_next         = st_reg;
        la_next         = la_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        pend_se_next    = pend_se_reg;
        push            = '0;
        unique case (seq_reg)
            SEQ_STREAM: begin
                if (s_fire) begin
                    if (s_item.text_end) begin
                        la_next[cnt_eff] = s_item.in_byte;
                        cnt_next         = cnt_eff + 3'd1;
                        st_next          = st_eff;
                        pend_valid_next  = 1'b0;
                    end else if (cnt_eff == 3'(AHEAD)) begin
                        st_next                 = st_judged;
                        la_next[AHEAD-1:0]      = win[WINDOW-1:1];
                        push.valid              = jres.emit;
                        push.item.out_byte      = jres.ob;
                        push.item.statement_end = jres.se;
                        push.item.text_done     = 1'b0;
                    end else begin
                        la_next[cnt_eff] = s_item.in_byte;
                        cnt_next         = cnt_eff + 3'd1;
                        st_next          = st_eff;
                    end
                end
            end
            SEQ_FLUSH: begin
                if (out_free) begin
                    if (cnt_reg != 3'd0) begin
                        st_next            = st_judged;
                        la_next[AHEAD-1:0] = la_reg[WINDOW-1:1];
                        cnt_next           = cnt_reg - 3'd1;
                        // hold the latest kept byte so the last one can carry the close
                        if (jres.emit) begin
                            push.valid              = pend_valid_reg;
                            push.item.out_byte      = pend_byte_reg;
                            push.item.statement_end = pend_se_reg;
                            push.item.text_done     = 1'b0;
                            pend_valid_next         = 1'b1;
                            pend_byte_next          = jres.ob;
                            pend_se_next            = jres.se;
                        end
                    end else begin
                        push.valid              = 1'b1;
                        push.item.out_byte      = pend_valid_reg ? pend_byte_reg : 8'd0;
                        push.item.statement_end = 1'b1;
                        push.item.text_done     = 1'b1;
                        st_next                 = SCAN_CLEAR;
                        cnt_next                = 3'd0;
                        pend_valid_next         = 1'b0;
                    end
                end
            end
            default: begin
                take_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg        <= SEQ_STREAM;
            st_reg         <= SCAN_CLEAR;
            cnt_reg        <= 3'd0;
            pend_valid_reg <= 1'b0;
        end else begin
            seq_reg        <= seq_next;
            st_reg         <= st_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        la_reg        <= la_next;
        pend_byte_reg <= pend_byte_next;
        pend_se_reg   <= pend_se_next;
    end

endmodule

### rtl/core/statement_splitter_comment_skip.sv
`timescale 1ns / 1ps
// Statement splitter with comment and html run removal: top level.
// Depends on ssc_pkg and ssc_core.
//
// Usage:
//   s_valid/s_ready/s_data carry one source byte per beat with text_start and
//   text_end flags. m_valid/m_ready/m_data carry kept bytes with statement_end
//   and text_done. cfg_valid/cfg_ready/cfg_wdata write the terminator byte
//   (reset value semicolon); cfg_ready is always high, write only while idle.
// Latency and throughput:
//   One byte is accepted per cycle unless stalled or flushing. A byte is
//   judged once five later bytes are in the lookahead window; its result (if
//   kept) sits in m_data the cycle after the byte five places later is accepted.
//   A text_end beat starts a flush that judges the n queued bytes (1 to 6)
//   one per cycle while the output is free, then emits the closing beat;
//   s_ready is low throughout the flush.
// Reset: synchronous, active low; clears depths, quote state, mode, history
//   (newlines), the lookahead count and the output valid flag.
// Stall: while m_valid is high and m_ready low, the output register holds
//   and s_ready drops, so the scan and flush freeze.
module statement_splitter_comment_skip (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ssc_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ssc_pkg::out_item_t  m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_wdata
);
    import ssc_pkg::*;

    logic       m_valid_reg;
    out_item_t  m_data_reg;
    logic [7:0] terminator_reg;
    logic       out_free;
    logic       take_ok;
    logic       s_fire;
    out_push_t  push;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = take_ok;
    assign s_fire    = s_valid && take_ok;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    ssc_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_item     (s_data),
        .s_fire     (s_fire),
        .terminator (terminator_reg),
        .out_free   (out_free),
        .take_ok    (take_ok),
        .push       (push)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            terminator_reg <= TERM_RESET;
        end else if (cfg_valid) begin
            terminator_reg <= cfg_wdata;
        end
    end

    // output register: advance when empty or drained this cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= push.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && push.valid) begin
            m_data_reg <= push.item;
        end
    end

endmodule
